// File: rtl/core/jmsp_pkg.sv
// ----------------------------------------------------------------------------
// jmsp_pkg
// Shared types, marker codes and decode functions for the JPEG marker parser.
// ----------------------------------------------------------------------------
package jmsp_pkg;

    typedef logic [7:0]       t_byte;
    typedef logic [1:0]       t_ev_kind;
    typedef logic [1:0]       t_process;
    typedef logic [2:0]       t_samp_class;
    typedef logic [15:0]      t_len;
    typedef logic [31:0]      t_offset;
    typedef logic [5:0][7:0]  t_samp_arr;

    localparam t_ev_kind EV_STANDALONE = 2'd0;
    localparam t_ev_kind EV_SEGMENT    = 2'd1;
    localparam t_ev_kind EV_FRAME      = 2'd2;
    localparam t_ev_kind EV_NOT_JPEG   = 2'd3;

    localparam t_byte MK_PREFIX    = 8'hFF;
    localparam t_byte MK_SOI       = 8'hD8;
    localparam t_byte MK_EOI       = 8'hD9;
    localparam t_byte MK_LAST_RSVD = 8'hBF;
    localparam t_byte MK_RST0      = 8'hD0;
    localparam t_byte MK_RST7      = 8'hD7;
    localparam t_byte MK_SOF0      = 8'hC0;
    localparam t_byte MK_SOF1      = 8'hC1;
    localparam t_byte MK_SOF2      = 8'hC2;
    localparam t_byte MK_SOF3      = 8'hC3;
    localparam t_byte MK_SOF9      = 8'hC9;
    localparam t_byte MK_SOF10     = 8'hCA;
    localparam t_byte MK_SOF11     = 8'hCB;

    localparam t_byte SAMP_22 = 8'h22;
    localparam t_byte SAMP_21 = 8'h21;
    localparam t_byte SAMP_11 = 8'h11;

    localparam t_process PROC_BASELINE    = 2'd0;
    localparam t_process PROC_EXTENDED    = 2'd1;
    localparam t_process PROC_PROGRESSIVE = 2'd2;
    localparam t_process PROC_LOSSLESS    = 2'd3;

    localparam t_samp_class SC_OTHER = 3'd6;
    localparam t_samp_class SC_ID0   = 3'd3;

    function automatic logic is_frame_marker(input t_byte m);
        return ((m >= MK_SOF0) && (m <= MK_SOF3)) || ((m >= MK_SOF9) && (m <= MK_SOF11));
    endfunction

    function automatic t_process process_of(input t_byte m);
        t_process p;
        if (m == MK_SOF0) begin
            p = PROC_BASELINE;
        end else if ((m == MK_SOF1) || (m == MK_SOF9)) begin
            p = PROC_EXTENDED;
        end else if ((m == MK_SOF2) || (m == MK_SOF10)) begin
            p = PROC_PROGRESSIVE;
        end else begin
            p = PROC_LOSSLESS;
        end
        return p;
    endfunction

    // 0..2 for 22/21/11 luma, 3 for anything else
    function automatic logic [1:0] luma_class(input logic present, input t_byte s);
        logic [1:0] k;
        if (present && (s == SAMP_22)) begin
            k = 2'd0;
        end else if (present && (s == SAMP_21)) begin
            k = 2'd1;
        end else if (present && (s == SAMP_11)) begin
            k = 2'd2;
        end else begin
            k = 2'd3;
        end
        return k;
    endfunction

    function automatic t_samp_class sampling_class_of(input logic [5:0] p, input t_samp_arr s);
        logic [1:0]  k1;
        logic [1:0]  k0;
        logic        ids123;
        logic        ids012;
        t_samp_class c;
        k1 = luma_class(p[1], s[1]);
        k0 = luma_class(p[0], s[0]);
        ids123 = !p[0] && p[2] && (s[2] == SAMP_11) && p[3] && (s[3] == SAMP_11)
                 && !p[4] && !p[5];
        ids012 = p[1] && (s[1] == SAMP_11) && p[2] && (s[2] == SAMP_11)
                 && !p[3] && !p[4] && !p[5];
        if (ids123 && (k1 != 2'd3)) begin
            c = {1'b0, k1};
        end else if (ids012 && (k0 != 2'd3)) begin
            c = SC_ID0 + {1'b0, k0};
        end else begin
            c = SC_OTHER;
        end
        return c;
    endfunction

endpackage

// File: rtl/core/jmsp_stream_if.sv
// ----------------------------------------------------------------------------
// jmsp_stream_if
// Valid/ready channels for the byte input and the marker event output.
// ----------------------------------------------------------------------------
interface jmsp_in_if import jmsp_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  file_start;

    modport source (output valid, output data_byte, output file_start, input ready);
    modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface jmsp_out_if import jmsp_pkg::*; ();
    logic        valid;
    logic        ready;
    t_ev_kind    event_kind;
    t_byte       marker_code;
    t_offset     marker_offset;
    t_len        segment_length;
    t_len        image_width;
    t_len        image_height;
    t_process    frame_process;
    t_samp_class sampling_class;
    t_byte       component_count;

    modport source (output valid, output event_kind, output marker_code,
                    output marker_offset, output segment_length, output image_width,
                    output image_height, output frame_process, output sampling_class,
                    output component_count, input ready);
    modport sink   (input valid, input event_kind, input marker_code,
                    input marker_offset, input segment_length, input image_width,
                    input image_height, input frame_process, input sampling_class,
                    input component_count, output ready);
endinterface

// File: rtl/core/jpeg_marker_stream_parser_top.sv
// ----------------------------------------------------------------------------
// jpeg_marker_stream_parser_top
// Byte-wide JPEG marker parser: SOI/EOI, segment lengths and frame headers.
// ----------------------------------------------------------------------------
// events: an event is valid in the cycle after the byte that causes it is taken
// throughput: one byte per cycle while the input is not stalled;
// a byte is taken while the event register is empty or being drained
// reset: synchronous active low, parser expects SOI as the first two bytes
module jpeg_marker_stream_parser_top import jmsp_pkg::*; #(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    jmsp_in_if.sink      i_in,
    jmsp_out_if.source   o_out
);

    localparam int EXT_W = OFFSET_WIDTH + 32;

    localparam logic [3:0] PH_SOI0     = 4'd0;
    localparam logic [3:0] PH_SOI1     = 4'd1;
    localparam logic [3:0] PH_SOI1_BAD = 4'd2;
    localparam logic [3:0] PH_HUNT     = 4'd3;
    localparam logic [3:0] PH_GOT_FF   = 4'd4;
    localparam logic [3:0] PH_LEN_HI   = 4'd5;
    localparam logic [3:0] PH_LEN_LO   = 4'd6;
    localparam logic [3:0] PH_FRAME    = 4'd7;
    localparam logic [3:0] PH_SKIP     = 4'd8;
    localparam logic [3:0] PH_EOI_HUNT = 4'd9;
    localparam logic [3:0] PH_EOI_FF   = 4'd10;
    localparam logic [3:0] PH_IGNORE   = 4'd11;

    logic [3:0]              r_phase,      n_phase,      c_phase;
    logic [OFFSET_WIDTH-1:0] r_byte_pos,   n_byte_pos,   c_byte_pos;
    logic [OFFSET_WIDTH-1:0] r_marker_pos, n_marker_pos, c_marker_pos;
    t_byte                   r_marker,     n_marker,     c_marker;
    t_len                    r_length,     n_length,     c_length;
    t_len                    r_remain,     n_remain,     c_remain;
    t_len                    r_hdr_idx,    n_hdr_idx,    c_hdr_idx;
    logic [1:0]              r_cphase,     n_cphase,     c_cphase;
    t_byte                   r_comp_total, n_comp_total, c_comp_total;
    t_byte                   r_pending_id, n_pending_id, c_pending_id;
    logic [5:0]              r_present,    n_present,    c_present;
    t_samp_arr               r_samp,       n_samp,       c_samp;
    t_len                    r_width,      n_width,      c_width;
    t_len                    r_height,     n_height,     c_height;

    logic                    in_acc;
    logic                    ev_valid;
    logic                    ev_frame;
    t_ev_kind                ev_kind;
    t_byte                   ev_code;
    logic [OFFSET_WIDTH-1:0] ev_pos;
    t_len                    ev_len;
    logic [EXT_W-1:0]        ev_pos_ext;
    logic [9:0]              hdr_end;
    logic                    hdr_done;
    t_byte                   b;

    logic                    r_out_valid,  n_out_valid;
    t_ev_kind                r_kind;
    t_byte                   r_code;
    t_offset                 r_offset;
    t_len                    r_seg_len;
    t_len                    r_img_w;
    t_len                    r_img_h;
    t_process                r_proc;
    t_samp_class             r_class;
    t_byte                   r_comp_cnt;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;

    // a new file restarts from the reset state before the byte is parsed
    always_comb begin
        if (i_in.file_start) begin
            c_phase      = PH_SOI0;
            c_byte_pos   = '0;
            c_marker_pos = '0;
            c_marker     = '0;
            c_length     = '0;
            c_remain     = '0;
            c_hdr_idx    = '0;
            c_cphase     = '0;
            c_comp_total = '0;
            c_pending_id = '0;
            c_present    = '0;
            c_samp       = '0;
            c_width      = '0;
            c_height     = '0;
        end else begin
            c_phase      = r_phase;
            c_byte_pos   = r_byte_pos;
            c_marker_pos = r_marker_pos;
            c_marker     = r_marker;
            c_length     = r_length;
            c_remain     = r_remain;
            c_hdr_idx    = r_hdr_idx;
            c_cphase     = r_cphase;
            c_comp_total = r_comp_total;
            c_pending_id = r_pending_id;
            c_present    = r_present;
            c_samp       = r_samp;
            c_width      = r_width;
            c_height     = r_height;
        end
    end

    always_comb begin
        n_phase      = c_phase;
        n_byte_pos   = c_byte_pos + OFFSET_WIDTH'(1);
        n_marker_pos = c_marker_pos;
        n_marker     = c_marker;
        n_length     = c_length;
        n_remain     = c_remain;
        n_hdr_idx    = c_hdr_idx;
        n_cphase     = c_cphase;
        n_comp_total = c_comp_total;
        n_pending_id = c_pending_id;
        n_present    = c_present;
        n_samp       = c_samp;
        n_width      = c_width;
        n_height     = c_height;
        ev_valid     = 1'b0;
        ev_frame     = 1'b0;
        ev_kind      = EV_STANDALONE;
        ev_code      = '0;
        ev_pos       = c_marker_pos;
        ev_len       = '0;
        hdr_end      = 10'd4 + 10'(n_comp_total) * 10'd3;
        hdr_done     = 1'b0;

        unique case (c_phase)
            PH_SOI0: begin
                n_phase = (b == MK_PREFIX) ? PH_SOI1 : PH_SOI1_BAD;
            end
            PH_SOI1, PH_SOI1_BAD: begin
                ev_valid = 1'b1;
                ev_pos   = '0;
                if ((c_phase == PH_SOI1) && (b == MK_SOI)) begin
                    ev_kind = EV_STANDALONE;
                    ev_code = MK_SOI;
                    n_phase = PH_HUNT;
                end else begin
                    ev_kind = EV_NOT_JPEG;
                    n_phase = PH_IGNORE;
                end
            end
            PH_HUNT, PH_EOI_HUNT: begin
                if (b == MK_PREFIX) begin
                    n_marker_pos = c_byte_pos;
                    n_phase      = (c_phase == PH_HUNT) ? PH_GOT_FF : PH_EOI_FF;
                end
            end
            PH_GOT_FF: begin
                priority if (b == MK_PREFIX) begin
                    n_marker_pos = c_byte_pos;
                end else if ((b <= MK_LAST_RSVD) || ((b >= MK_RST0) && (b <= MK_RST7))) begin
                    n_phase = PH_HUNT;
                end else if (b == MK_SOI) begin
                    ev_valid = 1'b1;
                    ev_code  = MK_SOI;
                    n_phase  = PH_HUNT;
                end else if (b == MK_EOI) begin
                    ev_valid = 1'b1;
                    ev_code  = MK_EOI;
                    n_phase  = PH_EOI_HUNT;
                end else begin
                    n_marker = b;
                    n_phase  = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                n_length = {b, 8'h00};
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_length = {c_length[15:8], b};
                n_remain = (n_length < 16'd2) ? 16'd0 : n_length - 16'd2;
                ev_code  = c_marker;
                ev_len   = n_length;
                if (is_frame_marker(c_marker)) begin
                    n_hdr_idx    = '0;
                    n_cphase     = '0;
                    n_comp_total = '0;
                    n_pending_id = '0;
                    n_present    = '0;
                    n_samp       = '0;
                    n_width      = '0;
                    n_height     = '0;
                    if (n_remain == 16'd0) begin
                        ev_valid = 1'b1;
                        ev_frame = 1'b1;
                        ev_kind  = EV_FRAME;
                        n_phase  = PH_HUNT;
                    end else begin
                        n_phase  = PH_FRAME;
                    end
                end else begin
                    ev_valid = 1'b1;
                    ev_kind  = EV_SEGMENT;
                    n_phase  = (n_remain != 16'd0) ? PH_SKIP : PH_HUNT;
                end
            end
            PH_FRAME: begin
                priority if (c_hdr_idx == 16'd1) begin
                    n_height = {b, 8'h00};
                end else if (c_hdr_idx == 16'd2) begin
                    n_height = {c_height[15:8], b};
                end else if (c_hdr_idx == 16'd3) begin
                    n_width = {b, 8'h00};
                end else if (c_hdr_idx == 16'd4) begin
                    n_width = {c_width[15:8], b};
                end else if (c_hdr_idx == 16'd5) begin
                    n_comp_total = b;
                    n_cphase     = 2'd0;
                end else if (c_hdr_idx >= 16'd6) begin
                    if (c_cphase == 2'd0) begin
                        n_pending_id = b;
                    end else if ((c_cphase == 2'd1) && (c_pending_id <= 8'd5)) begin
                        n_present[c_pending_id[2:0]] = 1'b1;
                        n_samp[c_pending_id[2:0]]    = b;
                    end
                    n_cphase = (c_cphase == 2'd2) ? 2'd0 : c_cphase + 2'd1;
                end else begin
                    n_hdr_idx = c_hdr_idx;
                end
                hdr_end   = 10'd4 + 10'(n_comp_total) * 10'd3;
                n_remain  = c_remain - 16'd1;
                n_hdr_idx = c_hdr_idx + 16'd1;
                hdr_done  = (c_hdr_idx >= 16'd5) && (c_hdr_idx >= {6'b0, hdr_end});
                if (hdr_done || (n_remain == 16'd0)) begin
                    ev_valid = 1'b1;
                    ev_frame = 1'b1;
                    ev_kind  = EV_FRAME;
                    ev_code  = c_marker;
                    ev_len   = c_length;
                    n_phase  = (n_remain != 16'd0) ? PH_SKIP : PH_HUNT;
                end
            end
            PH_SKIP: begin
                if (c_remain != 16'd0) begin
                    n_remain = c_remain - 16'd1;
                end
                if (n_remain == 16'd0) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_EOI_FF: begin
                priority if (b == MK_PREFIX) begin
                    n_marker_pos = c_byte_pos;
                end else if (b == MK_SOI) begin
                    ev_valid = 1'b1;
                    ev_code  = MK_SOI;
                    n_phase  = PH_HUNT;
                end else begin
                    n_phase  = PH_EOI_HUNT;
                end
            end
            default: begin
                n_phase = PH_IGNORE;
            end
        endcase

        if (ev_valid && (ev_kind != EV_NOT_JPEG) && (c_phase != PH_SOI1)) begin
            ev_pos = n_marker_pos;
        end
        ev_pos_ext = {{32{1'b0}}, ev_pos};
    end

    always_comb begin
        if (in_acc && ev_valid) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SOI0;
            r_byte_pos   <= '0;
            r_marker_pos <= '0;
            r_marker     <= '0;
            r_length     <= '0;
            r_remain     <= '0;
            r_hdr_idx    <= '0;
            r_cphase     <= '0;
            r_comp_total <= '0;
            r_pending_id <= '0;
            r_present    <= '0;
            r_samp       <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_acc) begin
                r_phase      <= n_phase;
                r_byte_pos   <= n_byte_pos;
                r_marker_pos <= n_marker_pos;
                r_marker     <= n_marker;
                r_length     <= n_length;
                r_remain     <= n_remain;
                r_hdr_idx    <= n_hdr_idx;
                r_cphase     <= n_cphase;
                r_comp_total <= n_comp_total;
                r_pending_id <= n_pending_id;
                r_present    <= n_present;
                r_samp       <= n_samp;
                r_width      <= n_width;
                r_height     <= n_height;
            end
        end
    end

    // event payload
    always_ff @(posedge i_clk) begin
        if (in_acc && ev_valid) begin
            r_kind     <= ev_kind;
            r_code     <= ev_code;
            r_offset   <= ev_pos_ext[31:0];
            r_seg_len  <= ev_len;
            r_img_w    <= ev_frame ? n_width : 16'd0;
            r_img_h    <= ev_frame ? n_height : 16'd0;
            r_proc     <= ev_frame ? process_of(c_marker) : PROC_BASELINE;
            r_class    <= ev_frame ? sampling_class_of(n_present, n_samp) : 3'd0;
            r_comp_cnt <= ev_frame ? n_comp_total : 8'd0;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.event_kind      = r_kind;
    assign o_out.marker_code     = r_code;
    assign o_out.marker_offset   = r_offset;
    assign o_out.segment_length  = r_seg_len;
    assign o_out.image_width     = r_img_w;
    assign o_out.image_height    = r_img_h;
    assign o_out.frame_process   = r_proc;
    assign o_out.sampling_class  = r_class;
    assign o_out.component_count = r_comp_cnt;

endmodule

// File: rtl/core/jmsp_checker.sv
// ----------------------------------------------------------------------------
// jmsp_checker
// Port-level checks on the marker parser event channel.
// ----------------------------------------------------------------------------
module jmsp_checker import jmsp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input t_ev_kind    i_kind,
    input t_byte       i_code,
    input t_offset     i_offset,
    input t_len        i_seg_len,
    input t_len        i_img_w,
    input t_len        i_img_h,
    input t_byte       i_comp_cnt
);

    // held word stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("event dropped while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("event valid right after reset");

    a_standalone_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_kind == EV_STANDALONE)) |-> (i_seg_len == 16'd0))
        else $error("standalone marker with length");

    a_not_jpeg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_kind == EV_NOT_JPEG)) |->
        ((i_code == 8'd0) && (i_offset == 32'd0) && (i_seg_len == 16'd0)))
        else $error("not-jpeg word carries marker data");

    a_frame_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_kind != EV_FRAME)) |->
        ((i_img_w == 16'd0) && (i_img_h == 16'd0) && (i_comp_cnt == 8'd0)))
        else $error("frame fields set on non-frame word");

endmodule

bind jpeg_marker_stream_parser_top jmsp_checker u_jmsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.event_kind),
    .i_code      (o_out.marker_code),
    .i_offset    (o_out.marker_offset),
    .i_seg_len   (o_out.segment_length),
    .i_img_w     (o_out.image_width),
    .i_img_h     (o_out.image_height),
    .i_comp_cnt  (o_out.component_count)
);
